// ----- rtl/clp_pkg.sv -----
package clp_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // A sum of QUEUE_DEPTH signed 32-bit velocities.
    localparam int ACC_W       = 32 + $clog2(QUEUE_DEPTH);
    localparam int TIME_W      = 34;
    localparam int LAT_W       = 20;
    localparam int DT_W        = 16;
    localparam int CFG_IDX_W   = 2;
    localparam logic [DT_W-1:0] DT_RESET = 16'd3277;

    localparam logic [1:0] KIND_OBS  = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_PRED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACT_LAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_LAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] turn;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
    } t_qentry;

    function automatic logic [QADDR_W-1:0] q_next(input logic [QADDR_W-1:0] a);
        return (a == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    // Slot at offset count from head, modulo the queue depth.
    function automatic logic [QADDR_W-1:0] q_slot(input logic [QADDR_W-1:0] head,
                                                  input logic [QCNT_W-1:0]  count);
        logic [QCNT_W:0] s;
        s = {{(QCNT_W + 1 - QADDR_W){1'b0}}, head} + {1'b0, count};
        if (s >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
            s = s - (QCNT_W + 1)'(QUEUE_DEPTH);
        end
        return s[QADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/command_latency_predictor.sv -----
// Channel   Direction  tdata (low bit up)                                tuser
// s_axis    in         now_us, pos_x, pos_y, heading, vel_x, vel_y,      kind
//                      turn_rate
// m_axis    out        pred_x, pred_y, pred_heading, pred_vel_x,         compensated,
//                      pred_vel_y, pred_turn_rate                        overflowed
// cfg       in         i_cfg_we, i_cfg_idx, i_cfg_data (no read-back)
//
// Observation and command items are stored as they are taken. A compensated predict item
// reads the queue memory one entry per cycle, then one
// shared multiplier scales the three velocity sums in turn. A raw predict item skips both.
// Reset is synchronous and empties the queue at once through its count.
// The block takes no new item while a predict item is in work; a finished result
// waits in the output register and only a second result stalls on it.
module command_latency_predictor
    import clp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // now_us, pos_x, pos_y, heading, vel_x, vel_y, turn_rate
    input  logic [223:0]         s_axis_tdata,
    // kind
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pred_x, pred_y, pred_heading, pred_vel_x, pred_vel_y, pred_turn_rate
    output logic [191:0]         m_axis_tdata,
    // compensated, overflowed
    output logic [1:0]           m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LAT_W-1:0]     i_cfg_data
);

    t_state r_state, n_state;

    logic [LAT_W-1:0] r_act_lat, r_obs_lat;
    logic [DT_W-1:0]  r_step_period;

    logic [31:0]              r_seen_x, r_seen_y, r_seen_h;
    logic signed [TIME_W-1:0] r_seen_time;
    logic                     r_seen_valid;
    logic [31:0]              r_latest_vx, r_latest_vy, r_latest_vt;

    logic [QADDR_W-1:0] r_head;
    logic [QCNT_W-1:0]  r_count;
    logic               r_drop;

    t_qentry r_mem [QUEUE_DEPTH];
    t_qentry r_rd_data;

    logic [QADDR_W-1:0]       r_rd_ptr;
    logic [QCNT_W-1:0]        r_left;
    logic                     r_rd_vld, r_popping, r_found;
    logic signed [TIME_W-1:0] r_cutoff, r_pend_cut;
    logic signed [ACC_W-1:0]  r_sum_x, r_sum_y, r_sum_h;
    logic [1:0]               r_step;

    logic [31:0] r_res_x, r_res_y, r_res_h, r_res_vx, r_res_vy, r_res_vt;
    logic        r_res_comp;

    logic         r_out_valid;
    logic [191:0] r_out_data;
    logic [1:0]   r_out_user;

    logic [1:0]  kind;
    logic [31:0] now_us;
    logic        in_acc, comp_now, out_load, mem_rd_en, mem_we, is_full;
    logic        stale, pending;
    logic [QADDR_W-1:0]      mem_waddr;
    t_qentry                 mem_wdata;
    logic signed [ACC_W-1:0] mac_sum;
    logic [31:0]             mac_pose_in, mac_pose;

    assign kind      = s_axis_tuser;
    assign now_us    = s_axis_tdata[31:0];
    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign comp_now  = r_seen_valid && (r_act_lat != '0 || r_obs_lat != '0);
    assign is_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign stale     = $signed({2'b00, r_rd_data.stamp}) <= r_cutoff;
    assign pending   = $signed({2'b00, r_rd_data.stamp}) >= r_pend_cut;

    assign mem_wdata.vel_x = s_axis_tdata[159:128];
    assign mem_wdata.vel_y = s_axis_tdata[191:160];
    assign mem_wdata.turn  = s_axis_tdata[223:192];
    assign mem_wdata.stamp = now_us;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && kind == KIND_PRED) begin
                    n_state = comp_now ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (r_left == '0) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_step == 2'd3) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mem_rd_en     = (r_state == ST_WALK) && (r_left != '0);
        mem_we        = in_acc && (kind == KIND_CMD);
        mem_waddr     = is_full ? r_head : q_slot(r_head, r_count);
        out_load      = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);
        case (r_step)
            2'd0: begin
                mac_sum     = r_sum_x;
                mac_pose_in = r_seen_x;
            end
            2'd1: begin
                mac_sum     = r_sum_y;
                mac_pose_in = r_seen_y;
            end
            default: begin
                mac_sum     = r_sum_h;
                mac_pose_in = r_seen_h;
            end
        endcase
    end

    clp_mac u_mac (
        .i_clk  (i_clk),
        .i_sum  (mac_sum),
        .i_dt   (r_step_period),
        .i_pose (mac_pose_in),
        .o_pose (mac_pose)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_act_lat     <= '0;
            r_obs_lat     <= '0;
            r_step_period <= DT_RESET;
            r_seen_x      <= '0;
            r_seen_y      <= '0;
            r_seen_h      <= '0;
            r_seen_time   <= '0;
            r_seen_valid  <= 1'b0;
            r_latest_vx   <= '0;
            r_latest_vy   <= '0;
            r_latest_vt   <= '0;
            r_head        <= '0;
            r_count       <= '0;
            r_drop        <= 1'b0;
            r_left        <= '0;
            r_rd_vld      <= 1'b0;
            r_popping     <= 1'b0;
            r_found       <= 1'b0;
            r_step        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACT_LAT: r_act_lat     <= i_cfg_data;
                    CFG_OBS_LAT: r_obs_lat     <= i_cfg_data;
                    CFG_STEP:    r_step_period <= i_cfg_data[DT_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                case (kind)
                    KIND_OBS: begin
                        r_seen_x     <= s_axis_tdata[63:32];
                        r_seen_y     <= s_axis_tdata[95:64];
                        r_seen_h     <= s_axis_tdata[127:96];
                        r_seen_time  <= $signed({2'b00, now_us})
                                        - $signed({{(TIME_W - LAT_W){1'b0}}, r_obs_lat});
                        r_seen_valid <= 1'b1;
                    end
                    KIND_CMD: begin
                        // A full queue loses its oldest entry to the new one.
                        if (is_full) begin
                            r_head <= q_next(r_head);
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        r_latest_vx <= mem_wdata.vel_x;
                        r_latest_vy <= mem_wdata.vel_y;
                        r_latest_vt <= mem_wdata.turn;
                    end
                    KIND_PRED: begin
                        r_left    <= r_count;
                        r_rd_vld  <= 1'b0;
                        r_popping <= 1'b1;
                        r_found   <= 1'b0;
                        r_step    <= '0;
                    end
                    default: ;
                endcase
            end

            if (r_state == ST_WALK) begin
                r_rd_vld <= mem_rd_en;
                if (mem_rd_en) begin
                    r_left <= r_left - 1'b1;
                end
                // Stale entries leave only while they are still at the head.
                if (r_rd_vld) begin
                    if (r_popping && stale) begin
                        r_head  <= q_next(r_head);
                        r_count <= r_count - 1'b1;
                    end else begin
                        r_popping <= 1'b0;
                        if (!r_found && pending) begin
                            r_found <= 1'b1;
                        end
                    end
                end
            end

            if (r_state == ST_MUL) begin
                r_step <= r_step + 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (in_acc && kind == KIND_PRED) begin
            r_res_x    <= r_seen_x;
            r_res_y    <= r_seen_y;
            r_res_h    <= r_seen_h;
            r_res_vx   <= r_latest_vx;
            r_res_vy   <= r_latest_vy;
            r_res_vt   <= r_latest_vt;
            r_res_comp <= comp_now;
            r_cutoff   <= r_seen_time - $signed({{(TIME_W - LAT_W){1'b0}}, r_act_lat});
            r_pend_cut <= $signed({2'b00, now_us})
                          - $signed({{(TIME_W - LAT_W){1'b0}}, r_act_lat});
            r_rd_ptr   <= r_head;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_sum_h    <= '0;
        end

        if (r_state == ST_WALK) begin
            if (mem_rd_en) begin
                r_rd_ptr <= q_next(r_rd_ptr);
            end
            if (r_rd_vld && !(r_popping && stale)) begin
                if (!r_found && pending) begin
                    r_res_vx <= r_rd_data.vel_x;
                    r_res_vy <= r_rd_data.vel_y;
                    r_res_vt <= r_rd_data.turn;
                end
                r_sum_x <= r_sum_x + ACC_W'($signed(r_rd_data.vel_x));
                r_sum_y <= r_sum_y + ACC_W'($signed(r_rd_data.vel_y));
                r_sum_h <= r_sum_h + ACC_W'($signed(r_rd_data.turn));
            end
        end

        // Each multiplier result comes from the product and pose registered in clp_mac.
        if (r_state == ST_MUL) begin
            case (r_step)
                2'd1:    r_res_x <= mac_pose;
                2'd2:    r_res_y <= mac_pose;
                2'd3:    r_res_h <= mac_pose;
                default: ;
            endcase
        end

        if (out_load) begin
            r_out_data <= {r_res_vt, r_res_vy, r_res_vx, r_res_h, r_res_y, r_res_x};
            r_out_user <= {r_drop, r_res_comp};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/clp_mac.sv -----
module clp_mac
    import clp_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [ACC_W-1:0] i_sum,
    input  logic [DT_W-1:0]         i_dt,
    input  logic [31:0]             i_pose,
    output logic [31:0]             o_pose
);

    localparam int PROD_W = ACC_W + DT_W + 1;

    logic signed [PROD_W-1:0] r_prod;
    logic [31:0]              r_pose;
    logic signed [PROD_W-1:0] rounded;

    always_ff @(posedge i_clk) begin
        r_prod <= i_sum * $signed({1'b0, i_dt});
        r_pose <= i_pose;
    end

    // Round half up to Q16.16, then add to the pose with wraparound.
    assign rounded = (r_prod + PROD_W'(32768)) >>> 16;
    assign o_pose  = r_pose + rounded[31:0];

endmodule
